[rtl/core/bst_pkg.sv]
package bst_pkg;

	localparam int LINE_COUNT_BITS_DEF = 16;
	localparam int LINE_W = 16;
	localparam int KIND_W = 4;
	localparam int CHAR_W = 8;
	localparam int CLASS_W = 2;
	localparam int CODE_W = 3;
	localparam int LEN_W = 3;
	localparam int PREFIX_DEPTH = 6;
	localparam int NUM_WORDS = 8;
	localparam int TYPE_CODE_FIRST = 6;
	localparam int FIFO_DEPTH = 4;

	typedef logic [CHAR_W-1:0] char_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_OP        = 4'd0,
		KIND_SEP       = 4'd1,
		KIND_DIGIT     = 4'd2,
		KIND_STR_CHAR  = 4'd3,
		KIND_STR_END   = 4'd4,
		KIND_WORD_CHAR = 4'd5,
		KIND_WORD_END  = 4'd6,
		KIND_UNKNOWN   = 4'd7,
		KIND_UNTERM    = 4'd8
	} kind_t;

	typedef enum logic [CLASS_W-1:0] {
		WCLASS_IDENT   = 2'd0,
		WCLASS_KEYWORD = 2'd1,
		WCLASS_TYPE    = 2'd2
	} wclass_t;

	typedef struct packed {
		kind_t             kind;
		char_t             char_value;
		wclass_t           word_class;
		logic [CODE_W-1:0] word_code;
		logic [LINE_W-1:0] line;
		logic              last;
	} result_t;

	typedef struct packed {
		wclass_t           word_class;
		logic [CODE_W-1:0] word_code;
	} word_match_t;

	// Reserved words, zero padded; the index is the word code.
	localparam char_t WORD_TEXT [NUM_WORDS][PREFIX_DEPTH] = '{
		'{"f", "u", "n", "c", 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00},
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"s", "t", "r", "i", "n", "g"}
	};

	localparam logic [LEN_W-1:0] WORD_LEN [NUM_WORDS] = '{
		3'd4, 3'd2, 3'd2, 3'd4, 3'd5, 3'd3, 3'd3, 3'd6
	};

	// Compares the held prefix against every reserved word in parallel.
	function automatic word_match_t match_word(input char_t prefix [PREFIX_DEPTH],
			input logic [LEN_W-1:0] len);
		word_match_t m;
		logic        same;
		m.word_class = WCLASS_IDENT;
		m.word_code  = '0;
		for (int k = NUM_WORDS - 1; k >= 0; k--) begin
			same = (WORD_LEN[k] == len);
			for (int i = 0; i < PREFIX_DEPTH; i++) begin
				if ((LEN_W'(i) < len) && (WORD_TEXT[k][i] != prefix[i])) begin
					same = 1'b0;
				end
			end
			if (same) begin
				m.word_class = (k >= TYPE_CODE_FIRST) ? WCLASS_TYPE : WCLASS_KEYWORD;
				m.word_code  = CODE_W'(k);
			end
		end
		return m;
	endfunction

endpackage

[rtl/core/bst_in_if.sv]
interface bst_in_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [bst_pkg::CHAR_W-1:0] byte_value;

	modport source (output valid, output action, output byte_value, input ready);
	modport sink (input valid, input action, input byte_value, output ready);
endinterface

[rtl/core/bst_out_if.sv]
interface bst_out_if;
	logic                        valid;
	logic                        ready;
	logic [bst_pkg::KIND_W-1:0]  kind;
	logic [bst_pkg::CHAR_W-1:0]  char_value;
	logic [bst_pkg::CLASS_W-1:0] word_class;
	logic [bst_pkg::CODE_W-1:0]  word_code;
	logic [bst_pkg::LINE_W-1:0]  line;
	logic                        last;

	modport source (output valid, output kind, output char_value, output word_class,
		output word_code, output line, output last, input ready);
	modport sink (input valid, input kind, input char_value, input word_class,
		input word_code, input line, input last, output ready);
endinterface

[rtl/core/byte_stream_tokenizer_unit.sv]
// Source text tokenizer: takes one byte (or an end-of-input mark) per item on
// source_bytes and gives zero, one or two result items on tokens, the final one
// of each input item marked by last. An accepted item is held in the input
// register and is then resolved combinationally by the classifier and word
// matcher into a four-entry result queue; a new item is taken every cycle
// as long as the queue holds at most two results. Items that give one result
// each therefore stream at one item per cycle while tokens takes every result
// offered; an item that gives two results (a word ended by a byte that gives a
// result of its own) needs a second pop, which the queue absorbs when followed
// by whitespace. The first result passes the input register and the result
// queue before it is offered. The line counter is LINE_COUNT_BITS wide and
// saturates; the reported line is capped at 65535.
module byte_stream_tokenizer_unit #(
	parameter int LINE_COUNT_BITS = bst_pkg::LINE_COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bst_in_if.sink     source_bytes,
	bst_out_if.source  tokens
);
	import bst_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		CL_OP, CL_SEP, CL_DIGIT, CL_ALPHA, CL_SPACE, CL_QUOTE, CL_OTHER
	} byte_class_t;

	// Input register.
	logic  valid_s1;
	logic  action_s1;
	char_t byte_s1;

	// Tokenizer state. The prefix bytes are only read once written for the
	// current word, so they have no reset.
	logic                       in_word_q;
	logic                       in_string_q;
	char_t                      prefix_q [PREFIX_DEPTH];
	logic [LEN_W-1:0]           word_len_q;
	logic [LINE_COUNT_BITS-1:0] line_q;

	// Result queue.
	result_t          fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic          accept;
	logic          process;
	logic          pop;
	logic          space;
	byte_class_t   bclass;
	word_match_t   wmatch;
	logic [31:0]   line_wide;
	logic [LINE_W-1:0] line_shown;
	result_t       res_a;
	result_t       res_b;
	logic          a_valid;
	logic          b_valid;
	result_t       slot0;
	result_t       slot1;
	logic [1:0]    push_n;
	logic          next_in_word;
	logic          next_in_string;
	logic          start_word;
	logic          extend_word;

	// The queue must hold both results an item can give before it is resolved.
	assign space   = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign process = valid_s1 && space;
	assign source_bytes.ready = !valid_s1 || space;
	assign accept  = source_bytes.valid && source_bytes.ready;
	assign pop     = tokens.valid && tokens.ready;

	always_comb begin
		case (byte_s1) inside
			"+", "=", "-", "/", "!", "*", "%", "|", "&": bclass = CL_OP;
			";", "(", ")", "{", "}", ",", ".", "[", "]": bclass = CL_SEP;
			[8'd9:8'd13], " ":                          bclass = CL_SPACE;
			"\"":                                        bclass = CL_QUOTE;
			["a":"z"], ["A":"Z"]:                        bclass = CL_ALPHA;
			["0":"9"]:                                   bclass = CL_DIGIT;
			default:                                     bclass = CL_OTHER;
		endcase
	end

	// Words longer than the prefix never match; WORD_LEN holds no such length.
	assign wmatch = match_word(prefix_q, word_len_q);

	assign line_wide  = 32'(line_q);
	assign line_shown = (line_wide > 32'(16'hFFFF)) ? 16'hFFFF : line_wide[LINE_W-1:0];

	// Result A is the word end of an open word; result B is whatever the byte
	// itself gives. A comes first when both are present.
	always_comb begin
		res_a.kind       = KIND_WORD_END;
		res_a.char_value = '0;
		res_a.word_class = wmatch.word_class;
		res_a.word_code  = wmatch.word_code;
		res_a.line       = line_shown;
		res_a.last       = 1'b0;

		res_b.kind       = KIND_UNKNOWN;
		res_b.char_value = byte_s1;
		res_b.word_class = WCLASS_IDENT;
		res_b.word_code  = '0;
		res_b.line       = line_shown;
		res_b.last       = 1'b0;

		a_valid        = 1'b0;
		b_valid        = 1'b0;
		next_in_word   = in_word_q;
		next_in_string = in_string_q;
		start_word     = 1'b0;
		extend_word    = 1'b0;

		if (action_s1) begin
			// End of input closes whatever is open.
			a_valid          = in_word_q;
			b_valid          = in_string_q;
			res_b.kind       = KIND_UNTERM;
			res_b.char_value = '0;
			next_in_word     = 1'b0;
			next_in_string   = 1'b0;
		end else if (in_string_q) begin
			b_valid = 1'b1;
			if (bclass == CL_QUOTE) begin
				res_b.kind       = KIND_STR_END;
				res_b.char_value = '0;
				next_in_string   = 1'b0;
			end else begin
				res_b.kind = KIND_STR_CHAR;
			end
		end else if (in_word_q && bclass == CL_ALPHA) begin
			b_valid     = 1'b1;
			res_b.kind  = KIND_WORD_CHAR;
			extend_word = 1'b1;
		end else begin
			// Any non-letter ends an open word, then counts as a fresh byte.
			a_valid      = in_word_q;
			next_in_word = 1'b0;
			case (bclass)
				CL_OP: begin
					b_valid    = 1'b1;
					res_b.kind = KIND_OP;
				end
				CL_SEP: begin
					b_valid    = 1'b1;
					res_b.kind = KIND_SEP;
				end
				CL_DIGIT: begin
					b_valid    = 1'b1;
					res_b.kind = KIND_DIGIT;
				end
				CL_ALPHA: begin
					b_valid      = 1'b1;
					res_b.kind   = KIND_WORD_CHAR;
					next_in_word = 1'b1;
					start_word   = 1'b1;
				end
				CL_QUOTE: begin
					next_in_string = 1'b1;
				end
				CL_SPACE: begin
				end
				default: begin
					b_valid    = 1'b1;
					res_b.kind = KIND_UNKNOWN;
				end
			endcase
		end

		if (a_valid) begin
			slot0      = res_a;
			slot1      = res_b;
			slot0.last = !b_valid;
			slot1.last = 1'b1;
		end else begin
			slot0      = res_b;
			slot1      = res_b;
			slot0.last = 1'b1;
			slot1.last = 1'b1;
		end
		push_n = process ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= source_bytes.action;
			byte_s1   <= source_bytes.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q   <= 1'b0;
			in_string_q <= 1'b0;
			word_len_q  <= '0;
			line_q      <= '0;
		end else if (process) begin
			in_word_q   <= next_in_word;
			in_string_q <= next_in_string;
			if (start_word) begin
				word_len_q <= LEN_W'(1);
			end else if (extend_word && word_len_q != '1) begin
				word_len_q <= word_len_q + 1'b1;
			end
			// Newlines count everywhere, strings included, after the results.
			if (!action_s1 && byte_s1 == 8'd10 && line_q != '1) begin
				line_q <= line_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			if (start_word) begin
				prefix_q[0] <= byte_s1;
			end else if (extend_word && word_len_q < LEN_W'(PREFIX_DEPTH)) begin
				prefix_q[word_len_q] <= byte_s1;
			end
		end
	end

	// Result queue: up to two pushes and one pop per cycle.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= slot0;
		end
		if (push_n == 2'd2) begin
			fifo_q[PTR_W'(wr_ptr_q + 1'b1)] <= slot1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(push_n));
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= CNT_W'(count_q + CNT_W'(push_n) - CNT_W'(pop));
		end
	end

	assign tokens.valid      = (count_q != '0);
	assign tokens.kind       = fifo_q[rd_ptr_q].kind;
	assign tokens.char_value = fifo_q[rd_ptr_q].char_value;
	assign tokens.word_class = fifo_q[rd_ptr_q].word_class;
	assign tokens.word_code  = fifo_q[rd_ptr_q].word_code;
	assign tokens.line       = fifo_q[rd_ptr_q].line;
	assign tokens.last       = fifo_q[rd_ptr_q].last;

endmodule
